>>> rtl/core/plti_pkg.sv
`timescale 1ns / 1ps
package plti_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W = 8;
  localparam int PIU_W = 9;
  localparam int ST_W = 3;
  localparam int DEF_TABLE_DEPTH = 256;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_CLAMPED   = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [ST_W-1:0] ST_UNORDERED = 3'd3;
  localparam logic [ST_W-1:0] ST_BEYOND    = 3'd4;

  typedef enum logic [1:0] {
    CLS_LOAD  = 2'd0,
    CLS_SKIP  = 2'd1,
    CLS_QUERY = 2'd2,
    CLS_EMPTY = 2'd3
  } cls_e;

  typedef struct packed {
    cls_e                     cls;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] gp;
    logic signed [DATA_W-1:0] tv;
    logic signed [DATA_W-1:0] qx;
  } cmd_t;

endpackage

>>> rtl/core/plti_front.sv
`timescale 1ns / 1ps
module plti_front #(
  parameter int NW = 9
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic [plti_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [plti_pkg::DATA_W-1:0] grid_point_i,
  input  logic signed [plti_pkg::DATA_W-1:0] table_value_i,
  input  logic signed [plti_pkg::DATA_W-1:0] query_x_i,
  input  logic [NW-1:0]                     n_used_i,
  output logic                              cmd_valid_o,
  output plti_pkg::cmd_t                    cmd_o,
  input  logic                              cmd_ready_i
);

  plti_pkg::cmd_t q_mem_q [2];
  plti_pkg::cmd_t in_cmd;
  logic           wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = q_mem_q[rd_ptr_q];

  // classify on entry; the user must change points_in_use only while idle, the block does not enforce it
  always_comb begin
    in_cmd.idx = entry_index_i;
    in_cmd.gp  = grid_point_i;
    in_cmd.tv  = table_value_i;
    in_cmd.qx  = query_x_i;
    if (!op_i) begin
      in_cmd.cls = (NW'(entry_index_i) >= n_used_i) ? plti_pkg::CLS_SKIP : plti_pkg::CLS_LOAD;
    end else begin
      in_cmd.cls = (n_used_i == '0) ? plti_pkg::CLS_EMPTY : plti_pkg::CLS_QUERY;
    end
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

>>> rtl/core/plti_back.sv
`timescale 1ns / 1ps
module plti_back #(
  parameter int TABLE_DEPTH = plti_pkg::DEF_TABLE_DEPTH,
  parameter int NW = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  input  plti_pkg::cmd_t                     cmd_i,
  output logic                               cmd_ready_o,
  input  logic [NW-1:0]                      n_used_i,
  output logic                               result_valid_o,
  output logic signed [plti_pkg::DATA_W-1:0] result_value_o,
  output logic [plti_pkg::ST_W-1:0]          status_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = plti_pkg::DATA_W;
  localparam int PW = 2 * DW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LRD   = 4'd1;
  localparam logic [3:0] S_LCK   = 4'd2;
  localparam logic [3:0] S_QFRD  = 4'd3;
  localparam logic [3:0] S_QFCK  = 4'd4;
  localparam logic [3:0] S_QLRD  = 4'd5;
  localparam logic [3:0] S_QLCK  = 4'd6;
  localparam logic [3:0] S_SCRD  = 4'd7;
  localparam logic [3:0] S_SCCK  = 4'd8;
  localparam logic [3:0] S_MUL0  = 4'd9;
  localparam logic [3:0] S_MUL1  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic signed [DW-1:0] bp_mem [TABLE_DEPTH];
  logic signed [DW-1:0] val_mem [TABLE_DEPTH];
  logic signed [DW-1:0] rd_g_q, rd_v_q;
  logic [AW-1:0]        raddr, waddr;
  logic                 we;
  logic signed [DW-1:0] wg, wv;

  logic [3:0]           state_q, state_d;
  plti_pkg::cmd_t       cmd_q, cmd_d;
  logic [AW-1:0]        scan_q, scan_d;
  logic                 eq_first_q, eq_first_d;
  logic signed [DW-1:0] vf_q, vf_d, g1_q, g1_d, v0_q, v0_d, v1_q, v1_d;
  logic                 neg_q, neg_d;
  logic [DW:0]          mag_q, mag_d;
  logic [DW-1:0]        dx_q, dx_d, d_q, d_d, rem_q, rem_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [6:0]           cnt_q, cnt_d;
  logic                 oerr_q, oerr_d;
  logic                 ov_q, ov_d;
  logic signed [DW-1:0] oval_q, oval_d;
  logic [plti_pkg::ST_W-1:0] ost_q, ost_d;

  logic [AW-1:0]        last, cmd_addr;
  logic signed [DW:0]   dv;
  logic [DW:0]          rem_sh;
  logic signed [DW+2:0] sum;

  assign last = AW'(n_used_i - NW'(1));
  assign cmd_addr = AW'(NW'(cmd_q.idx));
  assign cmd_ready_o = (state_q == S_IDLE);
  assign result_valid_o = ov_q;
  assign result_value_o = oval_q;
  assign status_o = ost_q;

  // table storage, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      bp_mem[waddr] <= wg;
      val_mem[waddr] <= wv;
    end
    rd_g_q <= bp_mem[raddr];
    rd_v_q <= val_mem[raddr];
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    scan_d = scan_q;
    eq_first_d = eq_first_q;
    vf_d = vf_q;
    g1_d = g1_q;
    v0_d = v0_q;
    v1_d = v1_q;
    neg_d = neg_q;
    mag_d = mag_q;
    dx_d = dx_q;
    d_d = d_q;
    rem_d = rem_q;
    prod_d = prod_q;
    cnt_d = cnt_q;
    oerr_d = oerr_q;
    ov_d = 1'b0;
    oval_d = '0;
    ost_d = plti_pkg::ST_OK;
    raddr = scan_q;
    we = 1'b0;
    waddr = AW'(NW'(cmd_i.idx));
    wg = cmd_i.gp;
    wv = cmd_i.tv;
    dv = '0;
    rem_sh = {rem_q, prod_q[PW-1]};
    sum = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.cls)
            plti_pkg::CLS_SKIP: begin
              ov_d = 1'b1;
              ost_d = plti_pkg::ST_BEYOND;
            end
            plti_pkg::CLS_LOAD: begin
              if (cmd_i.idx == '0) begin
                we = 1'b1;
                oerr_d = 1'b0;
                ov_d = 1'b1;
              end else begin
                scan_d = AW'(NW'(cmd_i.idx) - NW'(1));
                state_d = S_LRD;
              end
            end
            plti_pkg::CLS_EMPTY: begin
              ov_d = 1'b1;
              ost_d = plti_pkg::ST_EMPTY;
            end
            default: begin
              if (oerr_q) begin
                ov_d = 1'b1;
                ost_d = plti_pkg::ST_UNORDERED;
              end else begin
                scan_d = '0;
                state_d = S_QFRD;
              end
            end
          endcase
        end
      end
      S_LRD: state_d = S_LCK;
      S_LCK: begin
        waddr = cmd_addr;
        wg = cmd_q.gp;
        wv = cmd_q.tv;
        we = 1'b1;
        if (cmd_q.gp <= rd_g_q) begin
          oerr_d = 1'b1;
        end
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      S_QFRD: state_d = S_QFCK;
      S_QFCK: begin
        if (cmd_q.qx < rd_g_q) begin
          ov_d = 1'b1;
          oval_d = rd_v_q;
          ost_d = plti_pkg::ST_CLAMPED;
          state_d = S_IDLE;
        end else begin
          eq_first_d = (cmd_q.qx == rd_g_q);
          vf_d = rd_v_q;
          scan_d = last;
          state_d = S_QLRD;
        end
      end
      S_QLRD: state_d = S_QLCK;
      S_QLCK: begin
        state_d = S_IDLE;
        if (cmd_q.qx > rd_g_q) begin
          ov_d = 1'b1;
          oval_d = rd_v_q;
          ost_d = plti_pkg::ST_CLAMPED;
        end else if (eq_first_q) begin
          ov_d = 1'b1;
          oval_d = vf_q;
        end else if (cmd_q.qx == rd_g_q) begin
          ov_d = 1'b1;
          oval_d = rd_v_q;
        end else begin
          // strictly inside: at least two entries
          g1_d = rd_g_q;
          v1_d = rd_v_q;
          scan_d = scan_q - AW'(1);
          state_d = S_SCRD;
        end
      end
      S_SCRD: state_d = S_SCCK;
      S_SCCK: begin
        if (scan_q != '0 && rd_g_q > cmd_q.qx) begin
          g1_d = rd_g_q;
          v1_d = rd_v_q;
          scan_d = scan_q - AW'(1);
          state_d = S_SCRD;
        end else if (g1_q <= rd_g_q) begin
          ov_d = 1'b1;
          ost_d = plti_pkg::ST_UNORDERED;
          state_d = S_IDLE;
        end else begin
          v0_d = rd_v_q;
          d_d = DW'((DW+1)'(g1_q) - (DW+1)'(rd_g_q));
          dx_d = DW'((DW+1)'(cmd_q.qx) - (DW+1)'(rd_g_q));
          dv = (DW+1)'(v1_q) - (DW+1)'(rd_v_q);
          neg_d = dv[DW];
          mag_d = dv[DW] ? (DW+1)'(-dv) : (DW+1)'(dv);
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        prod_d = PW'(mag_q * dx_q[DW/2-1:0]);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        prod_d = prod_q + (PW'(mag_q * dx_q[DW-1:DW/2]) << (DW/2));
        rem_d = '0;
        cnt_d = 7'(PW);
        state_d = S_DIV;
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_sh >= {1'b0, d_q}) begin
          rem_d = DW'(rem_sh - {1'b0, d_q});
          prod_d = {prod_q[PW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[DW-1:0];
          prod_d = {prod_q[PW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ov_d = 1'b1;
        state_d = S_IDLE;
        if (prod_q > PW'(34'h2_0000_0000)) begin
          oval_d = neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
          sum = neg_q ? ((DW+3)'(v0_q) - (DW+3)'(prod_q[DW+1:0]))
                      : ((DW+3)'(v0_q) + (DW+3)'(prod_q[DW+1:0]));
          if (sum > (DW+3)'(64'sd2147483647)) begin
            oval_d = {1'b0, {(DW-1){1'b1}}};
          end else if (sum < (DW+3)'(-64'sd2147483648)) begin
            oval_d = {1'b1, {(DW-1){1'b0}}};
          end else begin
            oval_d = sum[DW-1:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oerr_q <= 1'b0;
      ov_q <= 1'b0;
      oval_q <= '0;
      ost_q <= plti_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      oerr_q <= oerr_d;
      ov_q <= ov_d;
      oval_q <= oval_d;
      ost_q <= ost_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    scan_q <= scan_d;
    eq_first_q <= eq_first_d;
    vf_q <= vf_d;
    g1_q <= g1_d;
    v0_q <= v0_d;
    v1_q <= v1_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    dx_q <= dx_d;
    d_q <= d_d;
    rem_q <= rem_d;
    prod_q <= prod_d;
    cnt_q <= cnt_d;
  end

endmodule

>>> rtl/core/piecewise_linear_table_interp_unit.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake               | Payload
// command   | in        | start / busy            | op_i, entry_index_i, grid_point_i,
//           |           |                         | table_value_i, query_x_i
// result    | out       | result_valid_o strobe   | result_value_o, status_o
// config    | in        | cfg_valid_i/cfg_ready_o | cfg_wdata_i (points_in_use)
//
// Loads at index 0 or out of range finish without a table read; others first
// compare with the entry below. Queries read the first and last entries, then
// walk the table downward from the top, one entry at a time over the single
// registered memory read port, then run the split multiply and the restoring
// divider. Early exits (empty, flagged unordered, clamped, end hit) skip the
// multiply and divide; a segment found out of order ends right after the walk.
// Reset clears the queue, control state and the order error flag; table
// contents are undefined until loaded. A two-entry queue sits in front of the
// engine; busy rises when it is full. Results cannot be stalled.
module piecewise_linear_table_interp_unit #(
  parameter int TABLE_DEPTH = plti_pkg::DEF_TABLE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op_i,
  input  logic [plti_pkg::IDX_W-1:0]         entry_index_i,
  input  logic signed [plti_pkg::DATA_W-1:0] grid_point_i,
  input  logic signed [plti_pkg::DATA_W-1:0] table_value_i,
  input  logic signed [plti_pkg::DATA_W-1:0] query_x_i,
  output logic                               result_valid_o,
  output logic signed [plti_pkg::DATA_W-1:0] result_value_o,
  output logic [plti_pkg::ST_W-1:0]          status_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [plti_pkg::PIU_W-1:0]         cfg_wdata_i
);

  // wide enough for both the register and the clamped count
  localparam int NW = ($clog2(TABLE_DEPTH + 1) > plti_pkg::PIU_W) ?
                      $clog2(TABLE_DEPTH + 1) : plti_pkg::PIU_W;

  logic [plti_pkg::PIU_W-1:0] piu_q;
  logic [NW-1:0]              n_used;
  logic                       cmd_valid, cmd_ready;
  plti_pkg::cmd_t             cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= '0;
    end else if (cfg_valid_i) begin
      piu_q <= cfg_wdata_i;
    end
  end

  // counts above the table depth act as the depth
  assign n_used = (NW'(piu_q) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(piu_q);

  plti_front #(
    .NW(NW)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .op_i(op_i),
    .entry_index_i(entry_index_i),
    .grid_point_i(grid_point_i),
    .table_value_i(table_value_i),
    .query_x_i(query_x_i),
    .n_used_i(n_used),
    .cmd_valid_o(cmd_valid),
    .cmd_o(cmd),
    .cmd_ready_i(cmd_ready)
  );

  plti_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NW(NW)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i(cmd),
    .cmd_ready_o(cmd_ready),
    .n_used_i(n_used),
    .result_valid_o(result_valid_o),
    .result_value_o(result_value_o),
    .status_o(status_o)
  );

endmodule

>>> rtl/core/plti_checker.sv
`timescale 1ns / 1ps
module plti_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               result_valid_o,
  input logic signed [plti_pkg::DATA_W-1:0] result_value_o,
  input logic [plti_pkg::ST_W-1:0]          status_o
);

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o <= plti_pkg::ST_BEYOND)
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == plti_pkg::ST_EMPTY ||
    status_o == plti_pkg::ST_UNORDERED || status_o == plti_pkg::ST_BEYOND)
    |-> result_value_o == '0)
    else $error("error result carries nonzero value");

  a_no_result_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !result_valid_o)
    else $error("result strobe right after reset");

  a_busy_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an item");

endmodule

bind piecewise_linear_table_interp_unit plti_checker u_plti_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .start(start),
  .busy(busy),
  .result_valid_o(result_valid_o),
  .result_value_o(result_value_o),
  .status_o(status_o)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam int   RANDOM_ITEMS   = 1100;
  localparam int   WATCHDOG_LIMIT = 8000;   // covers the longest query with 2 queued ahead
  localparam int   MAX_PRINTS     = 60;
  localparam int   S32_MAX = 32'h7fff_ffff;
  localparam int   S32_MIN = 32'h8000_0000;

  typedef struct {
    int          value;
    logic [2:0]  status;
  } interp_result_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               op_i = OP_LOAD;
  logic [plti_pkg::IDX_W-1:0]         entry_index_i = '0;
  logic signed [plti_pkg::DATA_W-1:0] grid_point_i = '0;
  logic signed [plti_pkg::DATA_W-1:0] table_value_i = '0;
  logic signed [plti_pkg::DATA_W-1:0] query_x_i = '0;
  logic                               result_valid_o;
  logic signed [plti_pkg::DATA_W-1:0] result_value_o;
  logic [plti_pkg::ST_W-1:0]          status_o;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [plti_pkg::PIU_W-1:0]         cfg_wdata_i = '0;

  // Predictor state
  int             bp_tab [256];
  int             val_tab[256];
  bit             loaded [256];
  bit             order_flag;
  int             points_cfg;
  interp_result_t pending_results[$];

  int mismatch_count;
  int items_sent;
  int idle_pct;
  int quiet_cycles;

  always #2 clk_i = ~clk_i;

  piecewise_linear_table_interp_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .grid_point_i  (grid_point_i),
    .table_value_i (table_value_i),
    .query_x_i     (query_x_i),
    .result_valid_o(result_valid_o),
    .result_value_o(result_value_o),
    .status_o      (status_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int used_points();
    return (points_cfg > 256) ? 256 : points_cfg;
  endfunction

  // A query may read every used entry; never let it touch unwritten ones.
  function automatic bit query_safe();
    int n;
    n = used_points();
    if (n == 0 || order_flag) return 1'b1;
    for (int i = 0; i < n; i++) if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic interp_result_t interp_predict(logic op, int idx, int g, int v, int x);
    interp_result_t r;
    int             n, last, i;
    longint         g0, g1, v0, v1, dv, sum;
    bit [63:0]      mag, dx, span, quo;
    r.value  = 0;
    r.status = plti_pkg::ST_OK;
    n = used_points();
    if (op == OP_LOAD) begin
      if (idx >= n) begin
        r.status = plti_pkg::ST_BEYOND;
      end else begin
        if (idx == 0) order_flag = 1'b0;
        else if (g <= bp_tab[idx-1]) order_flag = 1'b1;
        bp_tab[idx]  = g;
        val_tab[idx] = v;
        loaded[idx]  = 1'b1;
      end
    end else if (n == 0) begin
      r.status = plti_pkg::ST_EMPTY;
    end else if (order_flag) begin
      r.status = plti_pkg::ST_UNORDERED;
    end else begin
      last = n - 1;
      if (x < bp_tab[0]) begin
        r.value = val_tab[0]; r.status = plti_pkg::ST_CLAMPED;
      end else if (x > bp_tab[last]) begin
        r.value = val_tab[last]; r.status = plti_pkg::ST_CLAMPED;
      end else if (x == bp_tab[0]) begin
        r.value = val_tab[0];
      end else if (x == bp_tab[last]) begin
        r.value = val_tab[last];
      end else begin
        // walk down to the last breakpoint not above x
        i = last - 1;
        while (i > 0 && bp_tab[i] > x) i--;
        g0 = bp_tab[i];   g1 = bp_tab[i+1];
        v0 = val_tab[i];  v1 = val_tab[i+1];
        if (g1 <= g0) begin
          r.status = plti_pkg::ST_UNORDERED;
        end else begin
          span = g1 - g0;
          dx   = longint'(x) - g0;
          dv   = v1 - v0;
          mag  = (dv < 0) ? -dv : dv;
          quo  = (mag * dx) / span;   // truncates toward zero on the magnitude
          if (quo > 64'h2_0000_0000) begin
            r.value = (dv < 0) ? S32_MIN : S32_MAX;
          end else begin
            sum = (dv < 0) ? v0 - longint'(quo) : v0 + longint'(quo);
            if (sum > S32_MAX) r.value = S32_MAX;
            else if (sum < S32_MIN) r.value = S32_MIN;
            else r.value = int'(sum);
          end
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // start stays high after an accepted item so back-to-back items need no
  // extra edge; anything other than another item drops it first.
  task automatic release_start();
    start <= 1'b0;
  endtask

  task automatic send_item(logic op, int idx, int g, int v, int x);
    int             gap;
    interp_result_t pred;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    op_i          <= op;
    entry_index_i <= idx[7:0];
    grid_point_i  <= g;
    table_value_i <= v;
    query_x_i     <= x;
    do @(posedge clk_i); while (busy);
    pred = interp_predict(op, idx, g, v, x);
    pending_results = {pending_results, pred};
    items_sent++;
  endtask

  // Register writes only with nothing in flight; every item yields a result.
  task automatic write_points(int value);
    release_start();
    wait (pending_results.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value[plti_pkg::PIU_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    points_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    interp_result_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h status=%0d",
                                  result_value_o, status_o));
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, exp_r.status));
        if (result_value_o !== exp_r.value)
          report_mismatch($sformatf("value got %h want %h", result_value_o, exp_r.value));
      end
    end
  end

  // Watchdog: cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int rand_s32();
    return int'($urandom);
  endfunction

  // Sorted distinct breakpoints, either spread over the full range or clustered.
  task automatic make_grid(int n, output int grid[$]);
    int     base;
    bit     dup;
    grid.delete();
    if ($urandom_range(1) == 0) begin
      do begin
        grid.delete();
        for (int i = 0; i < n; i++) grid = {grid, rand_s32()};
        if ($urandom_range(9) == 0) grid[0] = S32_MIN;
        if ($urandom_range(9) == 0) grid[n-1] = S32_MAX;
        grid.sort();
        dup = 1'b0;
        for (int i = 1; i < n; i++) if (grid[i] == grid[i-1]) dup = 1'b1;
      end while (dup);
    end else begin
      base = int'($urandom_range(32'h7fff_ffff)) - 32'sh4000_0000;
      for (int i = 0; i < n; i++) begin
        grid = {grid, base};
        base += ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 1 << 20);
      end
    end
  endtask

  function automatic int pick_query_x();
    int     n;
    longint lo, hi;
    n  = used_points();
    if (n == 0 || !loaded[0] || !loaded[n-1]) return rand_s32();
    lo = bp_tab[0];
    hi = bp_tab[n-1];
    case ($urandom_range(9))
      0, 1, 2, 3: return (hi > lo) ? int'(lo + ({$urandom, $urandom} % (hi - lo + 1))) : int'(lo);
      4, 5:       return bp_tab[$urandom_range(n - 1)];
      6:          return ($urandom_range(1) == 0) ? S32_MIN : S32_MAX;
      7:          return (lo > S32_MIN) ? int'(lo - 1) : int'(lo);
      8:          return (hi < S32_MAX) ? int'(hi + 1) : int'(hi);
      default:    return rand_s32();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_table();
    write_points(0);
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, S32_MIN);
    send_item(OP_LOAD, 0, 5, 6, 0);        // beyond the table
    send_item(OP_LOAD, 255, -1, -1, 0);
  endtask

  task automatic test_single_entry();
    write_points(1);
    send_item(OP_LOAD, 0, 32'h0001_0000, -5, 0);
    send_item(OP_QUERY, 0, 0, 0, 32'h0001_0000);   // exact hit
    send_item(OP_QUERY, 0, 0, 0, 32'h0000_ffff);   // below
    send_item(OP_QUERY, 0, 0, 0, S32_MAX);         // above
    send_item(OP_LOAD, 1, 0, 0, 0);                // beyond
  endtask

  task automatic test_full_range();
    write_points(2);
    send_item(OP_LOAD, 0, S32_MIN, S32_MAX, 0);
    send_item(OP_LOAD, 1, S32_MAX, S32_MIN, 0);
    send_item(OP_QUERY, 0, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0, S32_MIN + 1);
    send_item(OP_QUERY, 0, 0, 0, -1);
    send_item(OP_QUERY, 0, 0, 0, S32_MAX);
  endtask

  task automatic test_order_flag();
    write_points(3);
    send_item(OP_LOAD, 0, 0, 100, 0);
    send_item(OP_LOAD, 1, 32'h000a_0000, 200, 0);
    send_item(OP_LOAD, 2, 32'h000a_0000, 300, 0);  // equal breakpoint: flag set
    send_item(OP_QUERY, 0, 0, 0, 32'h0005_0000);
    send_item(OP_LOAD, 0, 0, 100, 0);              // index 0 clears the flag
    send_item(OP_QUERY, 0, 0, 0, 32'h0005_0000);
    send_item(OP_LOAD, 1, 32'h001e_0000, 200, 0);  // silently out of order
    send_item(OP_QUERY, 0, 0, 0, 32'h0007_0000);
  endtask

  // All 256 entries with an oversized points_in_use, then exactly 256.
  task automatic test_full_table();
    int grid[$];
    write_points(511);
    make_grid(256, grid);
    for (int i = 0; i < 256; i++) send_item(OP_LOAD, i, grid[i], rand_s32(), 0);
    repeat (6) send_item(OP_QUERY, 0, 0, 0, pick_query_x());
    write_points(256);
    repeat (3) send_item(OP_QUERY, 0, 0, 0, pick_query_x());
  endtask

  task automatic table_session();
    int grid[$];
    int n, k, nq;
    case ($urandom_range(9))
      0:       n = $urandom_range(0, 1);
      1, 2:    n = $urandom_range(9, 40);
      default: n = $urandom_range(2, 8);
    endcase
    write_points(n);
    if (n > 0) make_grid(n, grid);
    for (int i = 0; i < n; i++) send_item(OP_LOAD, i, grid[i], rand_s32(), 0);
    nq = $urandom_range(8, 24);
    for (int j = 0; j < nq; j++) begin
      k = $urandom_range(99);
      if (k < 12 && n < 256) begin
        send_item(OP_LOAD, $urandom_range(n, 255), rand_s32(), rand_s32(), rand_s32());
      end else if (k < 20 && n > 0) begin
        // reload: may flag disorder, hide it, or clear the flag at index 0
        send_item(OP_LOAD, $urandom_range(n - 1), ($urandom_range(1) == 0) ?
                  rand_s32() : pick_query_x(), rand_s32(), 0);
      end else if (query_safe()) begin
        send_item(OP_QUERY, $urandom_range(255), rand_s32(), rand_s32(), pick_query_x());
      end
    end
  endtask

  task automatic test_random_sessions();
    int goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if (items_sent < goal - 2 * RANDOM_ITEMS / 3) idle_pct = 17;
      else if (items_sent < goal - RANDOM_ITEMS / 3) idle_pct = 83;
      else idle_pct = 0;
      table_session();
    end
  endtask

  initial begin
    mismatch_count = 0;
    items_sent     = 0;
    idle_pct       = 17;
    quiet_cycles   = 0;
    order_flag     = 1'b0;
    points_cfg     = 0;
    for (int i = 0; i < 256; i++) loaded[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_single_entry();
    test_full_range();
    test_order_flag();
    test_full_table();
    test_random_sessions();

    release_start();
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
